// File: src/jar_pkg.sv
// Shared constants, types and functions for the joystick average region ring block.
// Used by jar_lane, jar_merge and joystick_average_region_ring; no dependencies.
package jar_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 16;
  localparam int REGION_W   = 4;
  localparam int RING_LEDS  = 12;
  localparam int WINDOW     = 10;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // floor(sum / WINDOW) == (sum * RECIP) >> RECIP_SHIFT for every SUM_W-bit sum
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W     = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int ADDR_W     = 3;
  localparam int PDATA_W    = 32;

  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RESET  = SAMPLE_W'(1365);
  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RESET = SAMPLE_W'(2730);

  typedef enum logic {
    REG_LOW_THRESHOLD  = 1'b0,
    REG_HIGH_THRESHOLD = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_threshold;
    logic [SAMPLE_W-1:0] high_threshold;
  } thresholds_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  y_average;
    logic [SAMPLE_W-1:0]  x_average;
    logic [RING_LEDS-1:0] led_mask;
    logic [REGION_W-1:0]  region;
  } result_t;

  function automatic band_t band_of(input logic [SAMPLE_W-1:0] avg,
                                    input thresholds_t th);
    band_t b;
    if (avg < th.low_threshold) begin
      b = BAND_LOW;
    end else if (avg < th.high_threshold) begin
      b = BAND_MID;
    end else begin
      b = BAND_HIGH;
    end
    return b;
  endfunction

  function automatic logic [RING_LEDS-1:0] ring_mask(input logic [REGION_W-1:0] region);
    logic [RING_LEDS-1:0] m;
    case (region)
      4'd0:    m = 12'h180;
      4'd1:    m = 12'h0E0;
      4'd2:    m = 12'h030;
      4'd3:    m = 12'h700;
      4'd4:    m = 12'h000;
      4'd5:    m = 12'h01C;
      4'd6:    m = 12'hC00;
      4'd7:    m = 12'h803;
      4'd8:    m = 12'h006;
      default: m = 12'h000;
    endcase
    return m;
  endfunction

endpackage

// File: src/jar_lane.sv
// One axis lane: sample history, running sum and reciprocal divide by the window length.
// Depends on jar_pkg.
module jar_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [jar_pkg::SLOT_W-1:0]    slot,
  input  logic [jar_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          advance,
  output logic [jar_pkg::SAMPLE_W-1:0]  average
);

  logic [jar_pkg::SAMPLE_W-1:0] history [jar_pkg::WINDOW];
  logic [jar_pkg::SUM_W-1:0]    sum;
  logic [jar_pkg::SUM_W-1:0]    sum_next;
  logic [jar_pkg::PROD_W-1:0]   product;

  assign sum_next = jar_pkg::SUM_W'(sum - jar_pkg::SUM_W'(history[slot])
                                        + jar_pkg::SUM_W'(sample));
  assign product  = jar_pkg::PROD_W'(sum) * jar_pkg::PROD_W'(jar_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      for (int i = 0; i < jar_pkg::WINDOW; i++) begin
        history[i] <= '0;
      end
    end else if (load) begin
      sum           <= sum_next;
      history[slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      average <= product[jar_pkg::RECIP_SHIFT +: jar_pkg::SAMPLE_W];
    end
  end

endmodule

// File: src/jar_merge.sv
// Merging stage: bands both lane averages, forms the region and LED mask, holds the result.
// Depends on jar_pkg.
module jar_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [jar_pkg::SAMPLE_W-1:0]  x_average,
  input  logic [jar_pkg::SAMPLE_W-1:0]  y_average,
  input  jar_pkg::thresholds_t          thresholds,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jar_pkg::result_t              result
);

  jar_pkg::band_t           x_band;
  jar_pkg::band_t           y_band;
  logic [jar_pkg::REGION_W-1:0] region;

  assign x_band   = jar_pkg::band_of(x_average, thresholds);
  assign y_band   = jar_pkg::band_of(y_average, thresholds);
  assign region   = jar_pkg::REGION_W'(3 * jar_pkg::REGION_W'(y_band))
                  + jar_pkg::REGION_W'(x_band);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result.region    <= region;
      result.led_mask  <= jar_pkg::ring_mask(region);
      result.x_average <= x_average;
      result.y_average <= y_average;
    end
  end

endmodule

// File: src/joystick_average_region_ring.sv
// Top level of the joystick average region ring block: APB registers, slot counter, lanes.
// Depends on jar_pkg, jar_lane and jar_merge.
//
// Input stream s_*: one request per accepted beat carries an x and a y 12-bit sample.
// Output stream m_*: one result per request, in order: region code, ring LED mask
// and the truncated window averages of both axes.
// APB port: register 0 (low threshold) at address 0, register 1 (high threshold) at 4.
// Write the thresholds only while no request is in flight.
// Path: an accepted request passes the running sum update, the reciprocal multiply
// and the band and mask lookup into the output register, each registered in turn.
// Throughput: one request per cycle while the output is taken, set by the running
// sum update in each lane.
// Reset clears the histories, running sums, write slot and all valid flags, and
// loads the default thresholds.
// When the receiver stalls, the output register holds its result; the two stages
// ahead of it still fill, then s_tready drops until the output is taken.
module joystick_average_region_ring (
  input  logic                             clk,
  input  logic                             rst,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [jar_pkg::ADDR_W-1:0]       paddr,
  input  logic [jar_pkg::PDATA_W-1:0]      pwdata,
  output logic [jar_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [jar_pkg::IN_DATA_W-1:0]    s_tdata,   // x_sample[11:0], y_sample[23:12]
  // output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [jar_pkg::OUT_DATA_W-1:0]   m_tdata    // region[3:0], led_mask[15:4],
                                                      // x_average[27:16], y_average[39:28]
);

  jar_pkg::thresholds_t          thresholds;
  jar_pkg::reg_index_t           reg_index;
  logic                          cfg_write;
  logic [jar_pkg::SLOT_W-1:0]    slot;
  logic [jar_pkg::SLOT_W-1:0]    slot_next;
  logic                          valid_a;
  logic                          valid_b;
  logic                          ready_b;
  logic                          ready_o;
  logic                          accept;
  logic                          advance;
  logic [jar_pkg::SAMPLE_W-1:0]  x_average;
  logic [jar_pkg::SAMPLE_W-1:0]  y_average;
  jar_pkg::result_t              result;

  assign pready    = 1'b1;
  assign reg_index = jar_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_index)
      jar_pkg::REG_LOW_THRESHOLD:
        prdata = jar_pkg::PDATA_W'(thresholds.low_threshold);
      jar_pkg::REG_HIGH_THRESHOLD:
        prdata = jar_pkg::PDATA_W'(thresholds.high_threshold);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresholds.low_threshold  <= jar_pkg::LOW_THRESHOLD_RESET;
      thresholds.high_threshold <= jar_pkg::HIGH_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        jar_pkg::REG_LOW_THRESHOLD:
          thresholds.low_threshold  <= pwdata[jar_pkg::SAMPLE_W-1:0];
        jar_pkg::REG_HIGH_THRESHOLD:
          thresholds.high_threshold <= pwdata[jar_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign ready_b  = !valid_b || ready_o;
  assign s_tready = !valid_a || ready_b;
  assign accept   = s_tvalid && s_tready;
  assign advance  = valid_a && ready_b;

  assign slot_next = (slot == jar_pkg::SLOT_W'(jar_pkg::WINDOW - 1)) ? '0
                   : jar_pkg::SLOT_W'(slot + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (accept) begin
        slot <= slot_next;
      end
      if (s_tready) begin
        valid_a <= s_tvalid;
      end
      if (ready_b) begin
        valid_b <= valid_a;
      end
    end
  end

  jar_lane u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .slot    (slot),
    .sample  (s_tdata[jar_pkg::SAMPLE_W-1:0]),
    .advance (advance),
    .average (x_average)
  );

  jar_lane u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .slot    (slot),
    .sample  (s_tdata[2*jar_pkg::SAMPLE_W-1:jar_pkg::SAMPLE_W]),
    .advance (advance),
    .average (y_average)
  );

  jar_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (valid_b),
    .in_ready   (ready_o),
    .x_average  (x_average),
    .y_average  (y_average),
    .thresholds (thresholds),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result)
  );

  assign m_tdata = result;

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= jar_pkg::SLOT_W'(jar_pkg::WINDOW - 1))
    else $error("write slot beyond window");

  a_region_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[jar_pkg::REGION_W-1:0] <= jar_pkg::REGION_W'(8))
    else $error("region code out of range");

  a_center_dark: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[jar_pkg::REGION_W-1:0] == jar_pkg::REGION_W'(4))
      |-> m_tdata[jar_pkg::REGION_W +: jar_pkg::RING_LEDS] == '0)
    else $error("center region lights LEDs");

  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    $rose(valid_b) |-> $past(valid_a))
    else $error("multiply stage filled without a request ahead");

endmodule

// File: dv/tb_joystick_average_region_ring.sv
// Self-checking testbench for joystick_average_region_ring: a directed table, then phased
// random sample streams under changing thresholds, checked against a window-average model.
// Depends on jar_pkg and the joystick_average_region_ring RTL.
module tb_joystick_average_region_ring;
  import jar_pkg::*;

  typedef enum int {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        a;
    int        b;
    bit        typed;
    int        region;
    int        mask;
    int        xavg;
    int        yavg;
  } stim_row_t;

  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 9;
  localparam int DIRECTED_ROWS  = 25;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [ADDR_W-1:0]     paddr    = '0;
  logic [PDATA_W-1:0]    pwdata   = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  joystick_average_region_ring dut (.*);

  always #6 clk = ~clk;

  logic [SAMPLE_W-1:0]  x_hist [WINDOW];
  logic [SAMPLE_W-1:0]  y_hist [WINDOW];
  int unsigned          hist_slot = 0;
  logic [SUM_W-1:0]     x_sum = '0;
  logic [SUM_W-1:0]     y_sum = '0;
  logic [SAMPLE_W-1:0]  thr_low  = LOW_THRESHOLD_RESET;
  logic [SAMPLE_W-1:0]  thr_high = HIGH_THRESHOLD_RESET;
  logic [RING_LEDS-1:0] ring_leds [0:8] = '{12'h180, 12'h0E0, 12'h030,
                                            12'h700, 12'h000, 12'h01C,
                                            12'hC00, 12'h803, 12'h006};

  result_t     expected_results [$];
  stim_row_t   dir_tab [DIRECTED_ROWS];
  int          pairs_sent   = 0;
  int          results_seen = 0;
  int          writes_done  = 0;
  int          mismatches   = 0;
  int          idle_cycles  = 0;
  int          stall_left   = 0;
  bit          recv_stalls  = 1'b1;
  logic [15:0] regions_hit  = '0;

  function automatic band_t axis_band(input logic [SAMPLE_W-1:0] avg);
    if (avg < thr_low) return BAND_LOW;
    if (avg < thr_high) return BAND_MID;
    return BAND_HIGH;
  endfunction

  function automatic result_t window_step(input logic [SAMPLE_W-1:0] xs,
                                         input logic [SAMPLE_W-1:0] ys);
    result_t r;
    x_sum = x_sum - SUM_W'(x_hist[hist_slot]) + SUM_W'(xs);
    y_sum = y_sum - SUM_W'(y_hist[hist_slot]) + SUM_W'(ys);
    x_hist[hist_slot] = xs;
    y_hist[hist_slot] = ys;
    hist_slot = (hist_slot + 1) % WINDOW;
    r.x_average = SAMPLE_W'(x_sum / WINDOW);
    r.y_average = SAMPLE_W'(y_sum / WINDOW);
    r.region    = REGION_W'(3 * int'(axis_band(r.y_average)) + int'(axis_band(r.x_average)));
    r.led_mask  = ring_leds[r.region];
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] jitter_around(input int c, input int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic send_pair(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                           input bit typed, input result_t typed_r);
    result_t r;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {ys, xs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = window_step(xs, ys);
    expected_results.push_back(typed ? typed_r : r);
    pairs_sent++;
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input reg_index_t idx, input logic [SAMPLE_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= ($urandom() & ~PDATA_W'(SAMPLE_MAX)) | PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LOW_THRESHOLD) thr_low = val;
    else thr_high = val;
    writes_done++;
  endtask

  // receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (recv_stalls && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 12);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      regions_hit[got.region] = 1'b1;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result region=%0d mask=%h xavg=%0d yavg=%0d",
                             got.region, got.led_mask, got.x_average, got.y_average));
      end else begin
        want = expected_results.pop_front();
        if (got.region != want.region || got.led_mask != want.led_mask ||
            got.x_average != want.x_average || got.y_average != want.y_average) begin
          flag_error($sformatf({"result %0d: region %0d/%0d mask %h/%h xavg %0d/%0d ",
                                "yavg %0d/%0d (expected/actual)"}, results_seen,
                               want.region, got.region, want.led_mask, got.led_mask,
                               want.x_average, got.x_average, want.y_average, got.y_average));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               idle_cycles, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t           row;
    result_t             typed_r;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] xs;
    logic [SAMPLE_W-1:0] ys;
    bit                  quiet;
    bit                  send_gaps;
    int                  n;
    int                  sent;
    int                  seg_len;
    int                  mode;
    int                  cx;
    int                  cy;
    int                  spread;

    for (int i = 0; i < WINDOW; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    dir_tab = '{
      '{ROW_ITEM,  0,          0,          1, 0, 'h180, 0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 1, 0, 'h180, 409,  409},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 1, 8, 'h006, 4095, 4095},
      '{ROW_ITEM,  0,          SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, 0,          0, 0, 0,     0,    0},
      '{ROW_WRITE, REG_LOW_THRESHOLD,  0,          0, 0, 0, 0, 0},
      '{ROW_WRITE, REG_HIGH_THRESHOLD, SAMPLE_MAX, 0, 0, 0, 0, 0},
      '{ROW_ITEM,  2048,       1024,       0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_WRITE, REG_LOW_THRESHOLD,  SAMPLE_MAX, 0, 0, 0, 0, 0},
      '{ROW_WRITE, REG_HIGH_THRESHOLD, 0,          0, 0, 0, 0, 0},
      '{ROW_ITEM,  0,          0,          0, 0, 0,     0,    0},
      '{ROW_ITEM,  SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0,     0,    0},
      '{ROW_WRITE, REG_LOW_THRESHOLD,  1365, 0, 0, 0, 0, 0},
      '{ROW_WRITE, REG_HIGH_THRESHOLD, 2730, 0, 0, 0, 0, 0},
      '{ROW_ITEM,  'hAAA,      'h555,      0, 0, 0,     0,    0},
      '{ROW_ITEM,  'h555,      'hAAA,      0, 0, 0,     0,    0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        reg_write(reg_index_t'(row.a), SAMPLE_W'(row.b));
      end else begin
        typed_r.region    = REGION_W'(row.region);
        typed_r.led_mask  = RING_LEDS'(row.mask);
        typed_r.x_average = SAMPLE_W'(row.xavg);
        typed_r.y_average = SAMPLE_W'(row.yavg);
        send_pair(SAMPLE_W'(row.a), SAMPLE_W'(row.b), row.typed, typed_r);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiet       = (ph == RANDOM_PHASES - 1);
      recv_stalls = !quiet && ($urandom_range(0, 3) != 0);
      send_gaps   = !quiet && ($urandom_range(0, 3) != 0);
      drain();
      lo = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      hi = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      case ($urandom_range(0, 5))
        0: begin
          lo = LOW_THRESHOLD_RESET;
          hi = HIGH_THRESHOLD_RESET;
        end
        1: begin
          if (lo > hi) {lo, hi} = {hi, lo};
        end
        2: begin
          lo = '0;
          hi = SAMPLE_W'(SAMPLE_MAX);
        end
        3: begin
          lo = SAMPLE_W'(SAMPLE_MAX);
          hi = '0;
        end
        4: begin
          if (lo < hi) {lo, hi} = {hi, lo};
        end
        default: hi = lo;
      endcase
      reg_write(REG_LOW_THRESHOLD, lo);
      reg_write(REG_HIGH_THRESHOLD, hi);

      n    = quiet ? 150 : 120;
      sent = 0;
      while (sent < n) begin
        seg_len = $urandom_range(5, 30);
        mode    = $urandom_range(0, 5);
        cx      = $urandom_range(0, SAMPLE_MAX);
        cy      = $urandom_range(0, SAMPLE_MAX);
        spread  = $urandom_range(0, 600);
        for (int k = 0; k < seg_len && sent < n; k++) begin
          case (mode)
            4: begin
              xs = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
              ys = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            end
            5: begin
              xs = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
              ys = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            end
            default: begin
              xs = jitter_around(cx, spread);
              ys = jitter_around(cy, spread);
            end
          endcase
          if (send_gaps && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 13));
          send_pair(xs, ys, 1'b0, '0);
          sent++;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d sample pairs, %0d results and %0d threshold writes",
             pairs_sent, results_seen, writes_done);
    $display("Regions seen on the output (bit r = region r): %b", regions_hit[8:0]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
